// ===== sv/salc_pkg.sv =====
// Shared constants and types for the set-associative LRU cache tag store.
package salc_pkg;

  localparam int SETS  = 256;
  localparam int WAYS  = 4;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W     = WAY_W;
  localparam int WAY_OUT_W  = 2;
  localparam int OFF_W      = 4;
  localparam int IDX_W      = 4;
  localparam int NWAY_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [OFF_W-1:0]  OFF_RESET  = 4'd5;
  localparam logic [IDX_W-1:0]  IDX_RESET  = 4'd6;
  localparam logic [NWAY_W-1:0] NWAY_RESET = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS        = 2'd2
  } cfg_reg_t;

  // One memory row holds every way of a set.
  typedef struct packed {
    logic [WAYS-1:0][ADDR_W-1:0] tag;
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0]             dirty;
    logic [WAYS-1:0][RANK_W-1:0] rank;
  } set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             dirty_ev;
  } lookup_res_t;

endpackage

// ===== sv/salc_in_if.sv =====
// Access channel: address and load/store flag.
interface salc_in_if;
  import salc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              store_op;

  modport source (output valid, address, store_op, input ready);
  modport sink   (input valid, address, store_op, output ready);
endinterface

// ===== sv/salc_out_if.sv =====
// Result channel: hit, way and running counts.
interface salc_out_if;
  import salc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way_used;
  logic                 dirty_eviction;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;
  logic [CNT_W-1:0]     dirty_eviction_count;

  modport source (output valid, hit, way_used, dirty_eviction, hit_count, miss_count,
                  dirty_eviction_count, input ready);
  modport sink   (input valid, hit, way_used, dirty_eviction, hit_count, miss_count,
                  dirty_eviction_count, output ready);
endinterface

// ===== sv/set_assoc_lru_cache_tags.sv =====
// Top level: set-associative write-allocate cache tag store with LRU replacement.
// An accepted access is captured in the set/tag registers and the RAM read register; its
// result enters the output register once that register is free. A new access is taken only
// after the read of the set row and its read-modify-write, which waits while a result is not taken.
// Reset (synchronous, rst_n low): counts to zero, registers to 5/6/4, all sets read as
// empty at once through per-set row-written flags; no clearing pass.
module set_assoc_lru_cache_tags (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  salc_in_if.sink                        in_ch,
  salc_out_if.source                     out_ch
);
  import salc_pkg::*;

  typedef enum logic {IDLE, LOOK} state_t;

  state_t              state_r;
  logic [OFF_W-1:0]    off_bits_r;
  logic [IDX_W-1:0]    idx_bits_r;
  logic [NWAY_W-1:0]   ways_r;
  logic [SETS-1:0]     row_written_r;
  logic                row_ok_r;
  logic [SET_W-1:0]    set_r;
  logic [ADDR_W-1:0]   tag_r;
  logic                store_r;

  logic                out_valid_r;
  logic                out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic                out_dev_r;
  logic [CNT_W-1:0]    hits_r;
  logic [CNT_W-1:0]    misses_r;
  logic [CNT_W-1:0]    devs_r;
  logic [CNT_W-1:0]    hits_nxt;
  logic [CNT_W-1:0]    misses_nxt;
  logic [CNT_W-1:0]    devs_nxt;

  logic                in_xfer;
  logic                load;
  logic [ADDR_W-1:0]   shifted;
  logic [ADDR_W-1:0]   idx_mask;
  logic [SET_W-1:0]    set_idx;
  logic [ADDR_W-1:0]   tag;
  set_row_t            rd_row;
  set_row_t            row;
  set_row_t            row_nxt;
  lookup_res_t         res;

  assign in_ch.ready = (state_r == IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign load        = (state_r == LOOK) && (!out_valid_r || out_ch.ready);

  // address split
  always_comb begin
    shifted  = in_ch.address >> off_bits_r;
    idx_mask = (ADDR_W'(1) << idx_bits_r) - ADDR_W'(1);
    set_idx  = shifted[SET_W-1:0] & idx_mask[SET_W-1:0];
    tag      = in_ch.address >> (5'(off_bits_r) + 5'(idx_bits_r));
  end

  salc_set_ram #(.DEPTH(SETS), .WIDTH(ROW_W)) u_ram (
    .clk     (clk),
    .wr_en   (load),
    .wr_addr (set_r),
    .wr_data (row_nxt),
    .rd_en   (in_xfer),
    .rd_addr (set_idx),
    .rd_data (rd_row)
  );

  // a set never written reads as empty
  assign row = row_ok_r ? rd_row : '0;

  salc_way_update u_upd (
    .row      (row),
    .tag      (tag_r),
    .store_op (store_r),
    .ways_cfg (ways_r),
    .res      (res),
    .row_nxt  (row_nxt)
  );

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    devs_nxt   = devs_r;
    if (res.hit) begin
      if (hits_r != '1) hits_nxt = hits_r + CNT_W'(1);
    end else begin
      if (misses_r != '1) misses_nxt = misses_r + CNT_W'(1);
    end
    if (res.dirty_ev && (devs_r != '1)) devs_nxt = devs_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_bits_r <= OFF_RESET;
      idx_bits_r <= IDX_RESET;
      ways_r     <= NWAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_BITS: off_bits_r <= cfg_wdata[OFF_W-1:0];
        CFG_INDEX_BITS:  idx_bits_r <= cfg_wdata[IDX_W-1:0];
        CFG_WAYS:        ways_r     <= cfg_wdata[NWAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= IDLE;
      out_valid_r   <= 1'b0;
      row_written_r <= '0;
      row_ok_r      <= 1'b0;
      hits_r        <= '0;
      misses_r      <= '0;
      devs_r        <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && !load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_xfer) begin
            set_r    <= set_idx;
            tag_r    <= tag;
            store_r  <= in_ch.store_op;
            row_ok_r <= row_written_r[set_idx];
            state_r  <= LOOK;
          end
        end
        LOOK: begin
          if (load) begin
            row_written_r[set_r] <= 1'b1;
            hits_r      <= hits_nxt;
            misses_r    <= misses_nxt;
            devs_r      <= devs_nxt;
            out_valid_r <= 1'b1;
            out_hit_r   <= res.hit;
            out_way_r   <= WAY_OUT_W'(res.way);
            out_dev_r   <= res.dirty_ev;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.hit                  = out_hit_r;
  assign out_ch.way_used             = out_way_r;
  assign out_ch.dirty_eviction       = out_dev_r;
  assign out_ch.hit_count            = hits_r;
  assign out_ch.miss_count           = misses_r;
  assign out_ch.dirty_eviction_count = devs_r;

  // a transfer in always starts the row update
  a_xfer_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == LOOK))
    else $error("accepted access did not enter lookup");

  // each result moves exactly one of hit/miss counts unless saturated
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (hits_r != $past(hits_r)) || (misses_r != $past(misses_r)) ||
             ($past(hits_r) == '1) || ($past(misses_r) == '1))
    else $error("hit/miss count did not advance");

  // dirty eviction only on a miss
  a_dev_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_dev_r))
    else $error("dirty eviction flagged on a hit");

  a_dev_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.dirty_ev) |=> (devs_r != $past(devs_r)) || ($past(devs_r) == '1))
    else $error("dirty eviction not counted");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && row_written_r[$past(set_r)])
    else $error("result or row flag lost after update");

endmodule

// ===== sv/salc_set_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module salc_set_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 144
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/salc_way_update.sv =====
// Tag compare, victim choice and row update (recency ranks, dirty, fill).
module salc_way_update (
  input  salc_pkg::set_row_t          row,
  input  logic [salc_pkg::ADDR_W-1:0] tag,
  input  logic                        store_op,
  input  logic [salc_pkg::NWAY_W-1:0] ways_cfg,
  output salc_pkg::lookup_res_t       res,
  output salc_pkg::set_row_t          row_nxt
);
  import salc_pkg::*;

  localparam int WC_W = 5;
  localparam logic [WC_W-1:0] WAYS_L = WC_W'(WAYS);

  logic [WC_W-1:0]   ways_eff;
  logic [WAYS-1:0]   in_use;
  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   free;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  free_way;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  victim;
  logic [RANK_W-1:0] old_rank;
  logic              hit;
  logic              any_free;

  always_comb begin
    ways_eff = WC_W'(ways_cfg);
    if (ways_eff == '0) begin
      ways_eff = WC_W'(1);
    end else if (ways_eff > WAYS_L) begin
      ways_eff = WAYS_L;
    end
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = WC_W'(w) < ways_eff;
      match[w]  = in_use[w] && row.valid[w] && (row.tag[w] == tag);
      free[w]   = in_use[w] && !row.valid[w];
    end
    hit      = |match;
    any_free = |free;
    // lowest way wins
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (free[w])  free_way = WAY_W'(w);
    end
    lru_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (row.rank[w] < row.rank[lru_way])) lru_way = WAY_W'(w);
    end
    if (hit) begin
      victim = hit_way;
    end else if (any_free) begin
      victim = free_way;
    end else begin
      victim = lru_way;
    end

    res.hit      = hit;
    res.way      = victim;
    res.dirty_ev = !hit && !any_free && row.dirty[lru_way];

    row_nxt  = row;
    old_rank = row.rank[victim];
    for (int w = 0; w < WAYS; w++) begin
      if ((WAY_W'(w) != victim) && (row.rank[w] > old_rank)) begin
        row_nxt.rank[w] = row.rank[w] - RANK_W'(1);
      end
    end
    row_nxt.rank[victim] = RANK_W'(WAYS - 1);
    if (hit) begin
      row_nxt.dirty[victim] = row.dirty[victim] | store_op;
    end else begin
      row_nxt.tag[victim]   = tag;
      row_nxt.valid[victim] = 1'b1;
      row_nxt.dirty[victim] = store_op;
    end
  end

endmodule

// ===== tb/sv/set_assoc_lru_cache_tags_tb.sv =====
// Self-checking testbench for the set-associative LRU cache tag store.
module set_assoc_lru_cache_tags_tb;
  import salc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             hit;
    logic [1:0]       way;
    logic             dirty_ev;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] dirty_evs;
  } lookup_outcome_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  salc_in_if  in_ch ();
  salc_out_if out_ch ();

  set_assoc_lru_cache_tags i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the tag store
  logic [ADDR_W-1:0] tag_q   [SETS][WAYS];
  logic              valid_q [SETS][WAYS];
  logic              dirty_q [SETS][WAYS];
  logic [RANK_W-1:0] rank_q  [SETS][WAYS];
  logic [CNT_W-1:0]  hits_q, misses_q, dirty_evs_q;
  logic [3:0]        off_bits, idx_bits;
  logic [2:0]        ways_reg;

  lookup_outcome_t outcomes_due[$];
  int              failures;
  bit              idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("set_assoc_lru_cache_tags_tb NOT OK");
    $finish;
  end

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // Way becomes most recent; ranks above its old rank drop by one.
  function automatic void promote_way(int s, int way);
    logic [RANK_W-1:0] old;
    old = rank_q[s][way];
    for (int w = 0; w < WAYS; w++)
      if (w != way && rank_q[s][w] > old) rank_q[s][w]--;
    rank_q[s][way] = RANK_W'(WAYS - 1);
  endfunction

  function automatic lookup_outcome_t predict_lookup(logic [31:0] addr, logic st);
    lookup_outcome_t o;
    logic [31:0]     idx_mask, tag;
    int              n_ways, s, victim;
    bit              found;
    n_ways   = (ways_reg == 0) ? 1 : (ways_reg > WAYS) ? WAYS : int'(ways_reg);
    idx_mask = (32'd1 << idx_bits) - 32'd1;
    s        = int'(((addr >> off_bits) & idx_mask) % SETS);
    tag      = addr >> (int'(off_bits) + int'(idx_bits));
    o        = '0;
    victim   = 0;
    for (int w = 0; w < n_ways; w++)
      if (!o.hit && valid_q[s][w] && tag_q[s][w] == tag) begin
        o.hit  = 1'b1;
        victim = w;
      end
    if (o.hit) begin
      hits_q = sat_inc(hits_q);
      promote_way(s, victim);
      if (st) dirty_q[s][victim] = 1'b1;
    end else begin
      misses_q = sat_inc(misses_q);
      found = 0;
      for (int w = 0; w < n_ways; w++)
        if (!found && !valid_q[s][w]) begin
          victim = w;
          found  = 1;
        end
      if (!found) begin
        // strict compare: lowest way wins a tie
        victim = 0;
        for (int w = 1; w < n_ways; w++)
          if (rank_q[s][w] < rank_q[s][victim]) victim = w;
        if (dirty_q[s][victim]) begin
          o.dirty_ev  = 1'b1;
          dirty_evs_q = sat_inc(dirty_evs_q);
        end
      end
      tag_q[s][victim]   = tag;
      valid_q[s][victim] = 1'b1;
      dirty_q[s][victim] = st;
      promote_way(s, victim);
    end
    o.way       = 2'(victim);
    o.hits      = hits_q;
    o.misses    = misses_q;
    o.dirty_evs = dirty_evs_q;
    return o;
  endfunction

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      failures++;
    end
  endtask

  // Result check, config tracking and prediction, all on the rising edge.
  always @(posedge clk) begin
    lookup_outcome_t due;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got hit=%0b way=%0d",
                   $time, out_ch.hit, out_ch.way_used);
          failures++;
        end else begin
          due = outcomes_due.pop_front();
          compare_field("hit", 32'(due.hit), 32'(out_ch.hit));
          compare_field("way_used", 32'(due.way), 32'(out_ch.way_used));
          compare_field("dirty_eviction", 32'(due.dirty_ev), 32'(out_ch.dirty_eviction));
          compare_field("hit_count", due.hits, out_ch.hit_count);
          compare_field("miss_count", due.misses, out_ch.miss_count);
          compare_field("dirty_eviction_count", due.dirty_evs, out_ch.dirty_eviction_count);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_OFFSET_BITS: off_bits = cfg_wdata;
          CFG_INDEX_BITS:  idx_bits = cfg_wdata;
          CFG_WAYS:        ways_reg = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        outcomes_due.push_back(predict_lookup(in_ch.address, in_ch.store_op));
    end
  end

  // Result-side back-pressure in random bursts
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Returns just after the transfer edge; valid stays up until the next call.
  task automatic send_access(logic [31:0] addr, logic st);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.address  <= addr;
    in_ch.store_op <= st;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [3:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_geometry(logic [3:0] off, logic [3:0] idx, logic [2:0] ways);
    write_reg(CFG_OFFSET_BITS, off);
    write_reg(CFG_INDEX_BITS, idx);
    write_reg(CFG_WAYS, {1'b0, ways});
  endtask

  // Builds an address from tag, set and offset under the current geometry.
  function automatic logic [31:0] compose(logic [31:0] tag, logic [31:0] s,
                                          logic [31:0] low);
    logic [31:0] idx_mask, off_mask;
    idx_mask = (32'd1 << idx_bits) - 32'd1;
    off_mask = (32'd1 << off_bits) - 32'd1;
    return (tag << (int'(off_bits) + int'(idx_bits))) | ((s & idx_mask) << off_bits) |
           (low & off_mask);
  endfunction

  task automatic test_hit_and_store();
    // reset geometry: 32-byte lines, 64 sets, 4 ways; all traffic in set 3
    send_access(compose(7, 3, 0), 1'b0);
    send_access(compose(7, 3, 4), 1'b0);
    send_access(compose(7, 3, 31), 1'b1);
    send_access(compose(9, 3, 0), 1'b1);
    send_access(compose(11, 3, 0), 1'b0);
    send_access(compose(13, 3, 0), 1'b0);
    send_access(compose(7, 3, 0), 1'b0);
    // tag 9 is now least recent and dirty
    send_access(compose(15, 3, 0), 1'b0);
    send_access(compose(17, 3, 0), 1'b0);
  endtask

  task automatic test_ways_limits();
    set_geometry(4'd5, 4'd6, 3'd0);  // zero ways acts as one
    send_access(compose(1, 5, 0), 1'b1);
    send_access(compose(2, 5, 0), 1'b0);
    set_geometry(4'd5, 4'd6, 3'd7);  // above WAYS acts as WAYS
    send_access(compose(2, 5, 0), 1'b1);
    send_access(compose(3, 5, 0), 1'b1);
    send_access(compose(4, 5, 0), 1'b0);
    send_access(compose(5, 5, 0), 1'b1);
    send_access(compose(6, 5, 0), 1'b0);
  endtask

  task automatic test_address_extremes();
    set_geometry(4'd0, 4'd0, 3'd4);  // one set, tag is the whole address
    send_access(32'h0000_0000, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    // 15-bit index folds onto 256 sets; tag from bit 30 up
    set_geometry(4'd15, 4'd15, 3'd4);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'h7FFF_8000, 1'b1);
    send_access(32'h00FF_8000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_random_traffic(int n_items);
    logic [31:0] tag_pool[6];
    logic [31:0] set_pool[3];
    logic [31:0] addr;
    foreach (tag_pool[k]) tag_pool[k] = $urandom;
    foreach (set_pool[k]) set_pool[k] = $urandom;
    for (int i = 0; i < n_items; i++) begin
      // mostly a few tags over a few sets, so hits and evictions happen
      if ($urandom_range(0, 99) < 15)
        addr = $urandom;
      else
        addr = compose(tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 2)],
                       $urandom);
      send_access(addr, 1'($urandom));
      if (idle_on && $urandom_range(0, 79) == 0) wait_drained();
    end
  endtask

  task automatic test_random_geometries();
    set_geometry(4'd5, 4'd6, 3'd4);
    test_random_traffic(80);
    set_geometry(4'd0, 4'd0, 3'd1);
    test_random_traffic(80);
    set_geometry(4'd12, 4'd8, 3'd4);
    test_random_traffic(80);
    set_geometry(4'd15, 4'd15, 3'd7);
    test_random_traffic(80);
    set_geometry(4'd0, 4'd8, 3'd0);
    test_random_traffic(80);
    set_geometry(4'd3, 4'd2, 3'd2);
    test_random_traffic(80);
    set_geometry(4'd4, 4'd3, 3'd3);
    test_random_traffic(80);
    set_geometry(4'd9, 4'd12, 3'd5);
    test_random_traffic(80);
  endtask

  task automatic test_full_rate();
    set_geometry(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 3'($urandom_range(0, 7)));
    idle_on = 0;
    test_random_traffic(110);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_OFFSET_BITS;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.address  = '0;
    in_ch.store_op = 1'b0;
    idle_on        = 1;
    failures       = 0;
    hits_q         = '0;
    misses_q       = '0;
    dirty_evs_q    = '0;
    off_bits       = OFF_RESET;
    idx_bits       = IDX_RESET;
    ways_reg       = NWAY_RESET;
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        tag_q[s][w]   = '0;
        valid_q[s][w] = 1'b0;
        dirty_q[s][w] = 1'b0;
        rank_q[s][w]  = '0;
      end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_hit_and_store();
    test_ways_limits();
    test_address_extremes();
    test_random_geometries();
    test_full_rate();

    wait_drained();
    if (failures == 0)
      $display("set_assoc_lru_cache_tags_tb OK");
    else
      $display("set_assoc_lru_cache_tags_tb NOT OK");
    $finish;
  end

endmodule

// ===== set_assoc_lru_cache_tags.f =====
sv/salc_pkg.sv
sv/salc_in_if.sv
sv/salc_out_if.sv
sv/salc_set_ram.sv
sv/salc_way_update.sv
sv/set_assoc_lru_cache_tags.sv
tb/sv/set_assoc_lru_cache_tags_tb.sv
